FILE: design/wcrm_pkg.sv
package wcrm_pkg;

  typedef struct packed {
    logic [4:0]         client;
    logic signed [31:0] command_time;
    logic [31:0]        packet_number;
  } cmd_t;

  typedef struct packed {
    logic [9:0] commands_in_window;
    logic [9:0] packets_in_window;
  } res_t;

  typedef struct packed {
    logic in_range;
    cmd_t cmd;
  } queue_item_t;

  localparam logic [15:0] WINDOW_RESET = 16'd1000;
  localparam logic [9:0]  COUNT_MAX    = 10'd1023;

endpackage

FILE: design/windowed_command_rate_meter.sv
// Windowed command rate meter.
// Input queue: drive command and raise push; the item is taken on a clock
// edge where push is high and full is low. A two-entry queue holds items
// ahead of the scan engine.
// Result queue: while empty is low, result holds the oldest answer; raise
// pop to take it. One result comes out for every item, in order.
// Each item for a known client writes its timestamp and packet number
// into its client's ring, then the ring is read back oldest to newest, one
// entry per cycle through the ring RAM read port, counting commands within
// window_length of the newest timestamp and packet changes among them, the
// first hit counting as one. An item is taken from the queue while idle,
// written to its ring in S_LOAD, scanned in S_SCAN over the entries for
// that client including this one (at most RING_DEPTH), and answered in
// S_RESULT; one for an unknown client goes straight to S_RESULT. Items
// are handled one at a time: the next waits until the result is loaded.
// window_length is written by window_length_write, the user only while idle
// (unenforced); reset sets it to 1000 and empties every ring without clearing.
// If pop stays low, the result register holds and the engine waits with
// the next answer; input items keep queuing until full rises.
module windowed_command_rate_meter #(
  parameter int RING_DEPTH = 512,
  parameter int CLIENTS    = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  wcrm_pkg::cmd_t   command,
  output logic             empty,
  input  logic             pop,
  output wcrm_pkg::res_t   result,
  input  logic             window_length_write,
  input  logic [15:0]      window_length
);

  logic                  q_valid;
  logic                  q_take;
  wcrm_pkg::queue_item_t q_item;

  wcrm_front #(
    .CLIENTS (CLIENTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .command (command),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  wcrm_back #(
    .RING_DEPTH (RING_DEPTH),
    .CLIENTS    (CLIENTS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_take              (q_take),
    .window_length_write (window_length_write),
    .window_length       (window_length),
    .empty               (empty),
    .pop                 (pop),
    .result              (result)
  );

endmodule

FILE: design/wcrm_ram.sv
module wcrm_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/wcrm_front.sv
module wcrm_front #(
  parameter int CLIENTS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  wcrm_pkg::cmd_t           command,
  output logic                     q_valid,
  output wcrm_pkg::queue_item_t    q_item,
  input  logic                     q_take
);

  wcrm_pkg::queue_item_t entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       accept;

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wptr].in_range <= (32'(command.client) < CLIENTS);
      entries[wptr].cmd      <= command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        wptr <= ~wptr;
      end
      if (q_take) begin
        rptr <= ~rptr;
      end
      unique case ({accept, q_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/wcrm_back.sv
module wcrm_back #(
  parameter int RING_DEPTH = 512,
  parameter int CLIENTS    = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  wcrm_pkg::queue_item_t q_item,
  output logic                  q_take,
  input  logic                  window_length_write,
  input  logic [15:0]           window_length,
  output logic                  empty,
  input  logic                  pop,
  output wcrm_pkg::res_t        result
);

  localparam int SW    = $clog2(RING_DEPTH);
  localparam int FW    = $clog2(RING_DEPTH + 1);
  localparam int CW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int RW    = CW + SW;
  localparam int STW   = SW + FW;
  localparam int SUM_W = SW + 2;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t                state;
  logic [15:0]           window;
  wcrm_pkg::queue_item_t cur;
  logic [CW-1:0]         ci;
  logic [FW-1:0]         n;
  logic [FW-1:0]         issued;
  logic [SW-1:0]         idx;
  logic signed [32:0]    floor_time;
  logic                  rd_valid;
  logic [9:0]            cmds;
  logic [9:0]            pkts;
  logic                  have_prev;
  logic [31:0]           prev_packet;
  logic                  out_valid;
  wcrm_pkg::res_t        out_res;
  logic [CLIENTS-1:0]    client_valid;

  logic [CW-1:0]         st_raddr;
  logic [STW-1:0]        st_q;
  logic [SW-1:0]         st_ws;
  logic [FW-1:0]         st_fill;
  logic [SW-1:0]         slot;
  logic [SW-1:0]         ws_next;
  logic [FW-1:0]         fill_next;
  logic [SUM_W-1:0]      start_sum;
  logic [SW-1:0]         start;
  logic                  load;
  logic                  issue;
  logic [RW-1:0]         ring_raddr;
  logic [63:0]           ring_q;
  logic [31:0]           slot_time;
  logic [31:0]           slot_packet;
  logic                  hit;
  logic                  out_load;

  assign q_take   = (state == S_IDLE) && q_valid;
  assign load     = (state == S_LOAD);
  assign issue    = (state == S_SCAN) && (issued != n);
  assign st_raddr = (state == S_IDLE) ? CW'(q_item.cmd.client) : ci;
  assign out_load = (state == S_RESULT) && (!out_valid || pop);

  always_comb begin
    st_ws     = client_valid[ci] ? st_q[STW-1:FW] : '0;
    st_fill   = client_valid[ci] ? st_q[FW-1:0] : '0;
    slot      = (32'(st_ws) >= RING_DEPTH) ? '0 : st_ws;
    ws_next   = (32'(slot) + 32'd1 >= RING_DEPTH) ? '0 : slot + 1'b1;
    fill_next = (32'(st_fill) < RING_DEPTH) ? st_fill + 1'b1 : st_fill;
    start_sum = SUM_W'(ws_next) + SUM_W'(RING_DEPTH) - SUM_W'(fill_next);
    start     = (32'(start_sum) >= RING_DEPTH) ? SW'(start_sum - SUM_W'(RING_DEPTH))
                                               : SW'(start_sum);
  end

  assign ring_raddr  = {ci, idx};
  assign slot_time   = ring_q[63:32];
  assign slot_packet = ring_q[31:0];
  assign hit         = $signed({slot_time[31], slot_time}) >= floor_time;

  wcrm_ram #(
    .WIDTH  (STW),
    .DEPTH  (CLIENTS),
    .ADDR_W (CW)
  ) u_state_ram (
    .clk   (clk),
    .we    (load),
    .waddr (ci),
    .wdata ({ws_next, fill_next}),
    .raddr (st_raddr),
    .rdata (st_q)
  );

  wcrm_ram #(
    .WIDTH  (64),
    .DEPTH  (CLIENTS * (2 ** SW)),
    .ADDR_W (RW)
  ) u_ring_ram (
    .clk   (clk),
    .we    (load),
    .waddr ({ci, slot}),
    .wdata ({cur.cmd.command_time, cur.cmd.packet_number}),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_item;
      ci  <= CW'(q_item.cmd.client);
    end
    if (load) begin
      n          <= fill_next;
      idx        <= start;
      floor_time <= {cur.cmd.command_time[31], cur.cmd.command_time} - 33'(window);
    end else if (issue) begin
      idx <= (32'(idx) + 32'd1 >= RING_DEPTH) ? '0 : idx + 1'b1;
    end
    if (q_take) begin
      cmds      <= '0;
      pkts      <= '0;
      have_prev <= 1'b0;
      issued    <= '0;
    end else begin
      if (issue) begin
        issued <= issued + 1'b1;
      end
      if (rd_valid && hit) begin
        if (cmds < wcrm_pkg::COUNT_MAX) begin
          cmds <= cmds + 10'd1;
        end
        if ((!have_prev || slot_packet != prev_packet) && pkts < wcrm_pkg::COUNT_MAX) begin
          pkts <= pkts + 10'd1;
        end
        prev_packet <= slot_packet;
        have_prev   <= 1'b1;
      end
    end
    if (out_load) begin
      out_res.commands_in_window <= cmds;
      out_res.packets_in_window  <= pkts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window       <= wcrm_pkg::WINDOW_RESET;
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
      client_valid <= '0;
    end else begin
      if (window_length_write) begin
        window <= window_length;
      end
      rd_valid <= issue;
      if (load) begin
        client_valid[ci] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_item.in_range ? S_LOAD : S_RESULT;
          end
        end
        S_LOAD: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (issued == n && !rd_valid) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty  = !out_valid;
  assign result = out_res;

endmodule
